// ===== hdl/wcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// wcmr_pkg
// types, codes and helpers shared by the wrapped circle map rasteriser
// ----------------------------------------------------------------------------
package wcmr_pkg;

  localparam int unsigned MAP_DIM    = 256;
  localparam int unsigned MAX_RADIUS = 255;
  localparam int unsigned AW         = $clog2(MAP_DIM * MAP_DIM);
  localparam int unsigned CW         = 32;
  localparam int unsigned GW         = 9;
  localparam int unsigned IW         = 2;

  // request codes as seen on the input channel
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_DRAW  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // register indexes
  localparam logic [IW-1:0] REG_ROWS = 2'd0;
  localparam logic [IW-1:0] REG_COLS = 2'd1;
  localparam logic [IW-1:0] REG_MODE = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [7:0]         crow;
    logic [7:0]         ccol;
    logic [7:0]         rad;
    logic signed [15:0] val;
    logic [7:0]         rrow;
    logic [7:0]         rcol;
  } cmd_t;

  typedef struct packed {
    logic [GW-1:0] rows;
    logic [GW-1:0] cols;
    logic          mode;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_SETUP,
    ST_ROW,
    ST_SCAN,
    ST_WRITE,
    ST_RADDR,
    ST_RREAD,
    ST_RDATA,
    ST_DONE
  } st_e;

  // one restoring division step, remainder stays below n
  function automatic logic [GW-1:0] div_step(logic [GW-1:0] rem, logic b, logic [GW-1:0] n);
    logic [GW:0] t;
    t = {rem, b};
    if (t >= {1'b0, n}) t = t - {1'b0, n};
    return t[GW-1:0];
  endfunction

endpackage

// ===== hdl/wcmr_if.sv =====
// ----------------------------------------------------------------------------
// wcmr interfaces
// request, result and register write channels
// ----------------------------------------------------------------------------
interface wcmr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [7:0]         center_row;
  logic [7:0]         center_col;
  logic [7:0]         radius;
  logic signed [15:0] circle_value;
  logic [7:0]         read_row;
  logic [7:0]         read_col;
  modport source (output valid, req_type, center_row, center_col, radius, circle_value,
                  read_row, read_col, input ready);
  modport sink (input valid, req_type, center_row, center_col, radius, circle_value,
                read_row, read_col, output ready);
endinterface

interface wcmr_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cell_value;
  logic [17:0]        cells_hit;
  logic               status;
  modport source (output valid, cell_value, cells_hit, status, input ready);
  modport sink (input valid, cell_value, cells_hit, status, output ready);
endinterface

interface wcmr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/wcmr_front.sv =====
// ----------------------------------------------------------------------------
// wcmr_front
// accepts request items, decodes them and queues them for the engine
// ----------------------------------------------------------------------------
module wcmr_front import wcmr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wcmr_req_if.sink    req_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.crow = req_i.center_row;
    cmd_in.ccol = req_i.center_col;
    cmd_in.rad  = (req_i.radius > 8'(MAX_RADIUS)) ? 8'(MAX_RADIUS) : req_i.radius;
    cmd_in.val  = req_i.circle_value;
    cmd_in.rrow = req_i.read_row;
    cmd_in.rcol = req_i.read_col;
    unique case (req_i.req_type)
      REQ_CLEAR: cmd_in.op = OP_CLEAR;
      REQ_DRAW:  cmd_in.op = OP_DRAW;
      REQ_READ:  cmd_in.op = OP_READ;
      default:   cmd_in.op = OP_NOP;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= cmd_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

// ===== hdl/wcmr_back.sv =====
// ----------------------------------------------------------------------------
// wcmr_back
// scan engine with cell store, clearing pass and result register
// ----------------------------------------------------------------------------
module wcmr_back import wcmr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  cfg_t      cfg_i,
  wcmr_res_if.source res_o
);

  logic [CW-1:0] mem [MAP_DIM*MAP_DIM];
  logic [CW-1:0] rdata_q;

  st_e st_q, st_d;

  cmd_t               cmd_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               clr_res_q;
  logic [2:0]         wcnt_q;
  logic [7:0]         mag_r_q, mag_c_q;
  logic               neg_r_q, neg_c_q;
  logic [GW-1:0]      rem_r_q, rem_c_q;
  logic [7:0]         wr_q, wc_q, wc0_q;
  logic signed [9:0]  dr_q, dc_q, start_q;
  logic [16:0]        dr2_q, dc2_q, s0_q, rsq_q;
  logic [AW-1:0]      rowbase_q, addr_q;
  logic [17:0]        hits_q;
  logic [CW-1:0]      res_cell_q;
  logic               res_status_q;

  logic               out_valid_q;
  logic [CW-1:0]      out_cell_q;
  logic [17:0]        out_hits_q;
  logic               out_status_q;

  logic               mem_we, load_out, hit, last_col, last_row, rd_oob;
  logic [AW-1:0]      mem_wa, mem_ra, cell_addr;
  logic [CW-1:0]      mem_wd, val_ext;
  logic signed [9:0]  rad_s;
  logic signed [9:0]  ra, ca;
  logic [17:0]        dsum;

  assign rad_s     = $signed({2'b00, cmd_q.rad});
  assign last_col  = (dc_q == rad_s);
  assign last_row  = (dr_q == rad_s);
  assign cell_addr = rowbase_q + {{(AW-8){1'b0}}, wc_q};
  assign dsum      = {1'b0, dr2_q} + {1'b0, dc2_q};
  assign hit       = (dsum < {1'b0, rsq_q});
  assign val_ext   = {{(CW-16){cmd_q.val[15]}}, cmd_q.val};
  assign rd_oob    = ({1'b0, cmd_i.rrow} >= cfg_i.rows) || ({1'b0, cmd_i.rcol} >= cfg_i.cols);
  assign ra        = $signed({2'b00, cmd_i.crow}) - $signed({2'b00, cmd_i.rad});
  assign ca        = $signed({2'b00, cmd_i.ccol}) - $signed({2'b00, cmd_i.rad});

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (&clr_cnt_q) st_d = clr_res_q ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_CLEAR: st_d = ST_CLEAR;
            OP_DRAW:  st_d = (cmd_i.rad == 8'd0) ? ST_DONE : ST_WRAP;
            OP_READ:  st_d = rd_oob ? ST_DONE : ST_RADDR;
            default:  st_d = ST_DONE;
          endcase
        end
      end
      ST_WRAP:  if (wcnt_q == 3'd7) st_d = ST_SETUP;
      ST_SETUP: st_d = ST_ROW;
      ST_ROW:   st_d = ST_SCAN;
      ST_SCAN: begin
        if (hit) st_d = ST_WRITE;
        else if (last_col) st_d = last_row ? ST_DONE : ST_ROW;
      end
      ST_WRITE: begin
        if (last_col) st_d = last_row ? ST_DONE : ST_ROW;
        else st_d = ST_SCAN;
      end
      ST_RADDR: st_d = ST_RREAD;
      ST_RREAD: st_d = ST_RDATA;
      ST_RDATA: st_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || res_o.ready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = addr_q;
    mem_wd    = cfg_i.mode ? val_ext : rdata_q + val_ext;
    mem_ra    = addr_q;
    cmd_pop_o = 1'b0;
    load_out  = 1'b0;
    unique case (st_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt_q;
        mem_wd = '0;
      end
      ST_IDLE:  cmd_pop_o = cmd_valid_i;
      ST_SCAN:  mem_ra = cell_addr;
      ST_WRITE: mem_we = 1'b1;
      ST_DONE:  load_out = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  // datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      clr_cnt_q <= '0;
      clr_res_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        ST_CLEAR: clr_cnt_q <= clr_cnt_q + 1'b1;
        ST_IDLE: begin
          if (cmd_valid_i) begin
            clr_cnt_q <= '0;
            clr_res_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        cmd_q        <= cmd_i;
        hits_q       <= '0;
        res_cell_q   <= '0;
        res_status_q <= (cmd_i.op == OP_READ) && rd_oob;
        wcnt_q       <= '0;
        neg_r_q      <= ra[9];
        neg_c_q      <= ca[9];
        mag_r_q      <= ra[9] ? 8'(-ra) : ra[7:0];
        mag_c_q      <= ca[9] ? 8'(-ca) : ca[7:0];
        rem_r_q      <= '0;
        rem_c_q      <= '0;
      end
      ST_WRAP: begin
        rem_r_q <= div_step(rem_r_q, mag_r_q[7], cfg_i.rows);
        rem_c_q <= div_step(rem_c_q, mag_c_q[7], cfg_i.cols);
        mag_r_q <= {mag_r_q[6:0], 1'b0};
        mag_c_q <= {mag_c_q[6:0], 1'b0};
        wcnt_q  <= wcnt_q + 3'd1;
      end
      ST_SETUP: begin
        wr_q    <= (neg_r_q && rem_r_q != '0) ? 8'(cfg_i.rows - rem_r_q) : rem_r_q[7:0];
        wc0_q   <= (neg_c_q && rem_c_q != '0) ? 8'(cfg_i.cols - rem_c_q) : rem_c_q[7:0];
        wc_q    <= (neg_c_q && rem_c_q != '0) ? 8'(cfg_i.cols - rem_c_q) : rem_c_q[7:0];
        rsq_q   <= {1'b0, 16'(cmd_q.rad) * 16'(cmd_q.rad)};
        s0_q    <= {1'b0, 16'(cmd_q.rad - 8'd1) * 16'(cmd_q.rad - 8'd1)};
        dr2_q   <= {1'b0, 16'(cmd_q.rad - 8'd1) * 16'(cmd_q.rad - 8'd1)};
        dc2_q   <= {1'b0, 16'(cmd_q.rad - 8'd1) * 16'(cmd_q.rad - 8'd1)};
        start_q <= 10'sd1 - rad_s;
        dr_q    <= 10'sd1 - rad_s;
        dc_q    <= 10'sd1 - rad_s;
      end
      ST_ROW: rowbase_q <= AW'(wr_q) * AW'(cfg_i.cols);
      ST_SCAN, ST_WRITE: begin
        if (st_q == ST_SCAN) addr_q <= cell_addr;
        if (st_q == ST_WRITE) hits_q <= hits_q + 18'd1;
        if (st_q == ST_WRITE || !hit) begin
          if (last_col) begin
            dr_q  <= dr_q + 10'sd1;
            dr2_q <= 17'($signed({1'b0, dr2_q}) + $signed({dr_q, 1'b1}));
            wr_q  <= ({1'b0, wr_q} == cfg_i.rows - 9'd1) ? 8'd0 : wr_q + 8'd1;
            dc_q  <= start_q;
            dc2_q <= s0_q;
            wc_q  <= wc0_q;
          end else begin
            dc_q  <= dc_q + 10'sd1;
            dc2_q <= 17'($signed({1'b0, dc2_q}) + $signed({dc_q, 1'b1}));
            wc_q  <= ({1'b0, wc_q} == cfg_i.cols - 9'd1) ? 8'd0 : wc_q + 8'd1;
          end
        end
      end
      ST_RADDR: addr_q <= AW'(cmd_q.rrow) * AW'(cfg_i.cols) + {{(AW-8){1'b0}}, cmd_q.rcol};
      ST_RDATA: res_cell_q <= rdata_q;
      default: ;
    endcase
  end

  // result register, parts the engine from the result channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_cell_q   <= res_cell_q;
      out_hits_q   <= hits_q;
      out_status_q <= res_status_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.cell_value = out_cell_q;
  assign res_o.cells_hit  = out_hits_q;
  assign res_o.status     = out_status_q;

endmodule

// ===== hdl/wrapped_circle_map_rasterizer.sv =====
// ----------------------------------------------------------------------------
// wrapped_circle_map_rasterizer
// toroidal filled circle drawing and cell reads over a 256 x 256 map
// ----------------------------------------------------------------------------
// draw: decode, an 8-step wrap of the box corner and a set-up step, then per box row
//   a row step, a scan per box cell and a write per hit cell, then the result is loaded
// read: address, read and data steps to a result; clear: one store word per cycle
// zero radius, unknown request or out-of-grid read: straight to result; one item at a time
// after reset the same clearing pass runs; up to two items queue then
// result register plus a two-item queue let the input side run ahead
module wrapped_circle_map_rasterizer import wcmr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  wcmr_req_if.sink    req_i,
  wcmr_res_if.source  res_o,
  wcmr_cfg_if.sink    cfg_i
);

  logic [GW-1:0] rows_q, cols_q;
  logic          mode_q;
  cfg_t          cfg;
  cmd_t          cmd;
  logic          cmd_valid, cmd_pop;

  // register writes always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 9'd256;
      cols_q <= 9'd256;
      mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ROWS: rows_q <= cfg_i.data;
        REG_COLS: cols_q <= cfg_i.data;
        REG_MODE: mode_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // effective grid size: zero taken as one, oversize clamped to the map
  always_comb begin
    cfg.rows = (rows_q == '0) ? 9'd1 : (rows_q > GW'(MAP_DIM)) ? GW'(MAP_DIM) : rows_q;
    cfg.cols = (cols_q == '0) ? 9'd1 : (cols_q > GW'(MAP_DIM)) ? GW'(MAP_DIM) : cols_q;
    cfg.mode = mode_q;
  end

  // front: accept and decode
  wcmr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  // back: scan engine, cell store and result register
  wcmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg),
    .res_o       (res_o)
  );

endmodule
